// ===== rtl/perlin_noise_3d_top_defines.svh =====
// ----------------------------------------------------------------------------
// perlin_noise_3d_top_defines.svh
// Assertion macros used by the noise block checker.
// ----------------------------------------------------------------------------
`ifndef PERLIN_NOISE_3D_TOP_DEFINES_SVH
`define PERLIN_NOISE_3D_TOP_DEFINES_SVH

// Clocked check, masked while reset is active
`define PN3D_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define PN3D_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pn3d_pkg.sv =====
// ----------------------------------------------------------------------------
// pn3d_pkg
// Shared constants and operation codes of the 3D gradient noise block.
// ----------------------------------------------------------------------------
package pn3d_pkg;

	// Default geometry and number formats
	localparam int PN3D_TABLE_SIZE      = 256;
	localparam int PN3D_COORD_FRAC_BITS = 16;
	localparam int PN3D_GRAD_FRAC_BITS  = 15;

	// Internal working format and result format
	localparam int WORK_FRAC = 24;
	localparam int OUT_FRAC  = 15;
	localparam int NOISE_W   = 18;
	localparam int NOISE_MAX = 131071;
	localparam int NOISE_MIN = -131072;

	// Item operation codes
	typedef enum logic [1:0] {
		OP_LOAD_PERM = 2'd0,
		OP_LOAD_GRAD = 2'd1,
		OP_EVAL      = 2'd2
	} op_t;

endpackage

// ===== rtl/pn3d_blend.sv =====
// ----------------------------------------------------------------------------
// pn3d_blend
// Two-stage linear blend: y = a + floor(s * (b - a) / 2^CF).
// ----------------------------------------------------------------------------
module pn3d_blend import pn3d_pkg::*; #(
	parameter int CF = PN3D_COORD_FRAC_BITS,
	parameter int WW = 29
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [CF+1:0]        s,
	input  logic signed [WW-1:0] a,
	input  logic signed [WW-1:0] b,
	output logic                 out_vld,
	output logic signed [WW-1:0] y
);

	localparam int PW = CF + WW + 4;

	logic signed [WW:0]   diff;
	logic signed [CF+2:0] s_sgn;
	logic signed [PW-1:0] prod_s1;
	logic signed [WW-1:0] a_s1;
	logic                 vld_s1;
	logic signed [PW-1:0] sum;

	// Difference and signed weight
	assign diff  = (WW+1)'(b) - (WW+1)'(a);
	assign s_sgn = $signed({1'b0, s});

	// Stage one: weighted difference
	always_ff @(posedge clk) begin
		prod_s1 <= s_sgn * diff;
		a_s1    <= a;
	end

	// Stage two: add back the base value with a floor shift
	assign sum = PW'(a_s1) + (prod_s1 >>> CF);

	always_ff @(posedge clk) begin
		y <= sum[WW-1:0];
	end

	// Valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

endmodule

// ===== rtl/perlin_noise_3d_top.sv =====
// ----------------------------------------------------------------------------
// perlin_noise_3d_top
// Classic 3D gradient noise in fixed point, built around a permutation
// memory and a gradient memory with registered reads.
// ----------------------------------------------------------------------------
//   channel | signals                         | moves
//   --------+---------------------------------+-------------------------------
//   in      | in_valid, in_stall, op + fields | one load or evaluate item
//   out     | out_valid, out_stall, noise     | one noise value per evaluate
//
// A load writes its table entry at the transfer.
// An evaluate makes six permutation reads and eight gradient reads, one per
// cycle on single-port memories, then runs the corner and blend pipe before
// its result is shown.
// Reset clears control and noise only; tables are undefined until loaded.
// A result waiting on out_stall holds the block in its output state; the next
// item is taken as soon as the result is loaded into the output register.
// ----------------------------------------------------------------------------
module perlin_noise_3d_top import pn3d_pkg::*; #(
	parameter int TABLE_SIZE      = PN3D_TABLE_SIZE,
	parameter int COORD_FRAC_BITS = PN3D_COORD_FRAC_BITS,
	parameter int GRAD_FRAC_BITS  = PN3D_GRAD_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                operation,
	input  logic [7:0]                index,
	input  logic [7:0]                perm_value,
	input  logic signed [15:0]        grad_x,
	input  logic signed [15:0]        grad_y,
	input  logic signed [15:0]        grad_z,
	input  logic signed [31:0]        coord_x,
	input  logic signed [31:0]        coord_y,
	input  logic signed [31:0]        coord_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [NOISE_W-1:0] noise
);

	localparam int C      = COORD_FRAC_BITS;
	localparam int AW     = $clog2(TABLE_SIZE);
	localparam int HW     = (AW > 8) ? AW : 8;
	localparam int DW     = C + 20;
	localparam int SH     = C + GRAD_FRAC_BITS - WORK_FRAC;
	localparam int RSH    = (SH > 0) ? SH : 0;
	localparam int LSH    = (SH < 0) ? -SH : 0;
	localparam int WW     = DW + LSH - RSH;
	localparam int OUT_SH = WORK_FRAC - OUT_FRAC;
	localparam logic [C+1:0] W_THREE = (C+2)'(3 << C);
	localparam logic signed [WW-1:0] SAT_HI = WW'(NOISE_MAX);
	localparam logic signed [WW-1:0] SAT_LO = WW'(NOISE_MIN);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PERM,
		S_GRAD,
		S_DRAIN,
		S_OUT
	} state_t;

	state_t state_q;
	logic [2:0] step_q;
	logic       out_valid_q;
	logic signed [NOISE_W-1:0] noise_q;

	// Table memories
	logic [7:0]  perm_mem [TABLE_SIZE];
	logic [47:0] grad_mem [TABLE_SIZE];
	logic [7:0]  perm_rd_q;
	logic [47:0] grad_rd_q;
	logic [AW-1:0] perm_addr, perm_rd_addr, grad_addr, grad_rd_addr, load_idx;
	logic perm_we, grad_we, in_xfer;

	// Per-axis lattice cell, fraction and weight
	logic signed [31:0] coord_a [3];
	logic [AW-1:0] cell_in [3];
	logic [AW-1:0] cell0_q [3];
	logic [AW-1:0] cell1 [3];
	logic [C-1:0]  frac_q [3];
	logic [2*C-1:0] sq_w [3];
	logic [C-1:0]  t2_q [3];
	logic [C+1:0]  f_w [3];
	logic [2*C+1:0] sw_w [3];
	logic [C+1:0]  s_q [3];

	// Hashes
	logic [7:0] i_q, j_q;
	logic [7:0] h_q [4];
	logic       ptag_vld_q;
	logic [2:0] ptag_q;
	logic [7:0] h_sel;

	// Corner pipeline
	logic       gtag_vld_q;
	logic [2:0] gtag_q;
	logic signed [C+1:0]  r_sel [3];
	logic signed [15:0]   g_sel [3];
	logic signed [C+17:0] prod_s2 [3];
	logic       vld_s2, tag_s2;
	logic signed [DW-1:0]     dsum;
	logic signed [DW+LSH-1:0] dext, dsh;
	logic signed [WW-1:0] cv_s3;
	logic       cv_vld_s3, cv_tag_s3;

	// Blend tree
	logic signed [WW-1:0] xa_q, ya_q, za_q;
	logic signed [WW-1:0] x_y, y_y, z_y;
	logic x_vld, y_vld, z_vld;
	logic xpar_q, ypar_q;
	logic signed [WW-1:0] z_hold_q, z_sh, z_sat;

	function automatic logic [AW-1:0] hash_idx(input logic [7:0] h, input logic [AW-1:0] c);
		logic [HW-1:0] sum;
		sum = HW'(h) + HW'(c);
		return sum[AW-1:0];
	endfunction

	assign in_xfer   = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign noise     = noise_q;

	// Load address, wrapped to the table size
	always_comb begin
		logic [HW-1:0] ext;
		ext      = HW'(index);
		load_idx = ext[AW-1:0];
	end

	assign perm_we = in_xfer && (operation == OP_LOAD_PERM);
	assign grad_we = in_xfer && (operation == OP_LOAD_GRAD);

	// Cell split of the incoming coordinates
	assign coord_a[0] = coord_x;
	assign coord_a[1] = coord_y;
	assign coord_a[2] = coord_z;

	always_comb begin
		logic signed [31:0] ip;
		for (int k = 0; k < 3; k++) begin
			ip         = coord_a[k] >>> C;
			cell_in[k] = ip[AW-1:0];
			cell1[k]   = cell0_q[k] + AW'(1);
			sq_w[k]    = frac_q[k] * frac_q[k];
			f_w[k]     = W_THREE - {1'b0, frac_q[k], 1'b0};
			sw_w[k]    = t2_q[k] * f_w[k];
		end
	end

	// Permutation read address for each step
	always_comb begin
		unique case (step_q)
			3'd0:    perm_rd_addr = cell0_q[0];
			3'd1:    perm_rd_addr = cell1[0];
			3'd2:    perm_rd_addr = hash_idx(i_q, cell0_q[1]);
			3'd3:    perm_rd_addr = hash_idx(j_q, cell0_q[1]);
			3'd4:    perm_rd_addr = hash_idx(i_q, cell1[1]);
			default: perm_rd_addr = hash_idx(j_q, cell1[1]);
		endcase
	end

	assign perm_addr = (state_q == S_IDLE) ? load_idx : perm_rd_addr;

	// Gradient read address: corner bit 0 is x, bit 1 is y, bit 2 is z
	assign h_sel        = h_q[step_q[1:0]];
	assign grad_rd_addr = hash_idx(h_sel, step_q[2] ? cell1[2] : cell0_q[2]);
	assign grad_addr    = (state_q == S_IDLE) ? load_idx : grad_rd_addr;

	// Permutation memory
	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_addr] <= perm_value;
		end
		perm_rd_q <= perm_mem[perm_addr];
	end

	// Gradient memory
	always_ff @(posedge clk) begin
		if (grad_we) begin
			grad_mem[grad_addr] <= {grad_z, grad_y, grad_x};
		end
		grad_rd_q <= grad_mem[grad_addr];
	end

	// Capture coordinates and build the smoothing weights
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (in_xfer && operation == OP_EVAL) begin
				cell0_q[k] <= cell_in[k];
				frac_q[k]  <= coord_a[k][C-1:0];
			end
			if (state_q == S_PERM && step_q == 3'd0) begin
				t2_q[k] <= sq_w[k][2*C-1:C];
			end
			if (state_q == S_PERM && step_q == 3'd1) begin
				s_q[k] <= sw_w[k][2*C+1:C];
			end
		end
	end

	// Capture permutation read data by tag
	always_ff @(posedge clk) begin
		if (ptag_vld_q) begin
			unique case (ptag_q)
				3'd0:    i_q <= perm_rd_q;
				3'd1:    j_q <= perm_rd_q;
				3'd2:    h_q[0] <= perm_rd_q;
				3'd3:    h_q[1] <= perm_rd_q;
				3'd4:    h_q[2] <= perm_rd_q;
				default: h_q[3] <= perm_rd_q;
			endcase
		end
	end

	// Corner offsets and gradient components
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			r_sel[k] = gtag_q[k] ? $signed({2'b11, frac_q[k]}) : $signed({2'b00, frac_q[k]});
			g_sel[k] = grad_rd_q[16*k +: 16];
		end
	end

	// Corner products
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			prod_s2[k] <= r_sel[k] * g_sel[k];
		end
		tag_s2 <= gtag_q[0];
	end

	// Dot product brought to the working format
	assign dsum = DW'(prod_s2[0]) + DW'(prod_s2[1]) + DW'(prod_s2[2]);
	assign dext = (DW+LSH)'(dsum);
	assign dsh  = (dext <<< LSH) >>> RSH;

	always_ff @(posedge clk) begin
		cv_s3     <= dsh[WW-1:0];
		cv_tag_s3 <= tag_s2;
	end

	// Hold the even operand of each blend level and the final blend result
	always_ff @(posedge clk) begin
		if (cv_vld_s3 && !cv_tag_s3) begin
			xa_q <= cv_s3;
		end
		if (x_vld && !xpar_q) begin
			ya_q <= x_y;
		end
		if (y_vld && !ypar_q) begin
			za_q <= y_y;
		end
		if (z_vld) begin
			z_hold_q <= z_y;
		end
	end

	pn3d_blend #(.CF(C), .WW(WW)) u_blend_x (
		.clk(clk), .arst_n(arst_n), .in_vld(cv_vld_s3 && cv_tag_s3),
		.s(s_q[0]), .a(xa_q), .b(cv_s3), .out_vld(x_vld), .y(x_y)
	);

	pn3d_blend #(.CF(C), .WW(WW)) u_blend_y (
		.clk(clk), .arst_n(arst_n), .in_vld(x_vld && xpar_q),
		.s(s_q[1]), .a(ya_q), .b(x_y), .out_vld(y_vld), .y(y_y)
	);

	pn3d_blend #(.CF(C), .WW(WW)) u_blend_z (
		.clk(clk), .arst_n(arst_n), .in_vld(y_vld && ypar_q),
		.s(s_q[2]), .a(za_q), .b(y_y), .out_vld(z_vld), .y(z_y)
	);

	// Scale to the output format and clamp
	assign z_sh = z_hold_q >>> OUT_SH;

	always_comb begin
		priority if (z_sh > SAT_HI) begin
			z_sat = SAT_HI;
		end else if (z_sh < SAT_LO) begin
			z_sat = SAT_LO;
		end else begin
			z_sat = z_sh;
		end
	end

	// Pipeline valids and blend parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptag_vld_q <= 1'b0;
			ptag_q     <= 3'd0;
			gtag_vld_q <= 1'b0;
			gtag_q     <= 3'd0;
			vld_s2     <= 1'b0;
			cv_vld_s3  <= 1'b0;
			xpar_q     <= 1'b0;
			ypar_q     <= 1'b0;
		end else begin
			ptag_vld_q <= (state_q == S_PERM);
			ptag_q     <= step_q;
			gtag_vld_q <= (state_q == S_GRAD);
			gtag_q     <= step_q;
			vld_s2     <= gtag_vld_q;
			cv_vld_s3  <= vld_s2;
			if (in_xfer) begin
				xpar_q <= 1'b0;
				ypar_q <= 1'b0;
			end else begin
				if (x_vld) begin
					xpar_q <= !xpar_q;
				end
				if (y_vld) begin
					ypar_q <= !ypar_q;
				end
			end
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= 3'd0;
			out_valid_q <= 1'b0;
			noise_q     <= '0;
		end else begin
			// Drop the result after its transfer unless a new one is loaded
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					step_q <= 3'd0;
					if (in_xfer && operation == OP_EVAL) begin
						state_q <= S_PERM;
					end
				end
				S_PERM: begin
					if (step_q == 3'd5) begin
						step_q  <= 3'd0;
						state_q <= S_GRAD;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_GRAD: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (z_vld) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						noise_q     <= z_sat[NOISE_W-1:0];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/pn3d_chk.sv =====
// ----------------------------------------------------------------------------
// pn3d_chk
// Port-level checks for the 3D gradient noise block, bound to the top level.
// ----------------------------------------------------------------------------
`include "perlin_noise_3d_top_defines.svh"

module pn3d_chk import pn3d_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic [1:0]                operation,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [NOISE_W-1:0] noise
);

	// Hold a stalled result
	`PN3D_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")

	// Hold the noise value of a stalled result
	`PN3D_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(noise), "stalled noise changed")

	// Evaluate transfer makes the block busy
	`PN3D_ASSERT(a_eval_busy, in_valid && !in_stall && operation == OP_EVAL |=> in_stall, "evaluate did not block input")

	// No result appears right after an evaluate transfer
	`PN3D_ASSERT(a_eval_latency, in_valid && !in_stall && operation == OP_EVAL |=> !$rose(out_valid), "result too early")

	// No result during reset
	`PN3D_ASSERT_RST(a_reset_quiet, !arst_n |-> !out_valid, "result valid in reset")

endmodule

bind perlin_noise_3d_top pn3d_chk u_pn3d_chk (.*);
